// File: rtl/core/tdef_pkg.sv
// tdef_pkg: shared types and constants of the tail drop fifo with congestion marking
// used by tdef_cfg, tdef_core and tail_drop_ecn_fifo_top; no dependencies
package tdef_pkg;

    // item kinds on the slave side
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DEQ  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    // result codes on the master side
    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_MARKED = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_DEQ    = 3'd3;
    localparam logic [2:0] ST_PEEK   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_MODE     = 3'd0;
    localparam logic [2:0] REG_MAX_PACKETS   = 3'd1;
    localparam logic [2:0] REG_MAX_BYTES     = 3'd2;
    localparam logic [2:0] REG_MARK_BYTES    = 3'd3;
    localparam logic [2:0] REG_MARK_PACKETS  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // reset values of the configuration registers
    localparam logic        SIZE_MODE_RST    = 1'b0;
    localparam logic [7:0]  MAX_PACKETS_RST  = 8'd100;
    localparam logic [23:0] MAX_BYTES_RST    = 24'(100 * 1500);
    localparam logic [23:0] MARK_BYTES_RST   = 24'd100;
    localparam logic [7:0]  MARK_PACKETS_RST = 8'd100;

    localparam int ID_W    = 32;
    localparam int SIZE_W  = 16;
    localparam int OCC_P_W = 8;
    localparam int OCC_B_W = 23;

    typedef struct packed {
        logic        size_mode;
        logic [7:0]  max_packets;
        logic [23:0] max_bytes;
        logic [23:0] mark_thresh_bytes;
        logic [7:0]  mark_thresh_packets;
    } cfg_t;

endpackage

// File: rtl/core/tdef_ram.sv
// tdef_ram: generic single write port, single read port ram with registered read
// no dependencies
module tdef_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/tdef_cfg.sv
// tdef_cfg: configuration registers written over the config channel
// depends on tdef_pkg
module tdef_cfg
    import tdef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIZE_MODE:    cfg_next.size_mode           = cfg_data[0];
                REG_MAX_PACKETS:  cfg_next.max_packets         = cfg_data[7:0];
                REG_MAX_BYTES:    cfg_next.max_bytes           = cfg_data;
                REG_MARK_BYTES:   cfg_next.mark_thresh_bytes   = cfg_data;
                REG_MARK_PACKETS: cfg_next.mark_thresh_packets = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_mode           <= SIZE_MODE_RST;
            cfg_reg.max_packets         <= MAX_PACKETS_RST;
            cfg_reg.max_bytes           <= MAX_BYTES_RST;
            cfg_reg.mark_thresh_bytes   <= MARK_BYTES_RST;
            cfg_reg.mark_thresh_packets <= MARK_PACKETS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/tdef_core.sv
// tdef_core: queue control, pointers, occupancy counts, drop and mark decision, result register
// depends on tdef_pkg; drives the descriptor ram through its ports
module tdef_core
    import tdef_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_kind,
    input  logic [ID_W-1:0]             in_id,
    input  logic [SIZE_W-1:0]           in_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  out_status,
    output logic [ID_W-1:0]             out_id,
    output logic [SIZE_W-1:0]           out_size,
    output logic [OCC_P_W-1:0]          out_occ_p,
    output logic [OCC_B_W-1:0]          out_occ_b,
    output logic                        ram_we,
    output logic [$clog2(DEPTH)-1:0]    ram_waddr,
    output logic [ID_W+SIZE_W-1:0]      ram_wdata,
    output logic [$clog2(DEPTH)-1:0]    ram_raddr,
    input  logic [ID_W+SIZE_W-1:0]      ram_rdata
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int MAXB   = DEPTH * 65535;
    localparam int BW     = $clog2(MAXB + 1);
    localparam int PCMP_W = (CW > 8) ? CW : 8;
    localparam int BCMP_W = (BW > 24) ? BW : 24;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     pcnt_reg, pcnt_next;
    logic [BW-1:0]     bcnt_reg, bcnt_next;

    logic [1:0]        kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [SIZE_W-1:0] size_reg;

    logic              ovalid_reg, ovalid_next;
    logic [2:0]        ostatus_reg, ostatus_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [SIZE_W-1:0] osize_reg, osize_next;

    logic              out_free;
    logic              full;
    logic [CW-1:0]     ncount;
    logic [BW-1:0]     nbytes;
    logic              over;
    logic              mark;
    logic [ID_W-1:0]   hid;
    logic [SIZE_W-1:0] hsz;
    logic [BW-1:0]     hsz_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !ovalid_reg || out_ready;

    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_id     = oid_reg;
    assign out_size   = osize_reg;
    assign out_occ_p  = OCC_P_W'(pcnt_reg);
    assign out_occ_b  = OCC_B_W'(bcnt_reg);

    // head entry is read every cycle; data for the current item is ready in exec
    assign ram_raddr = head_reg;
    assign ram_waddr = tail_reg;
    assign ram_wdata = {size_reg, id_reg};

    assign hid     = ram_rdata[ID_W-1:0];
    assign hsz     = ram_rdata[ID_W+SIZE_W-1:ID_W];
    assign hsz_ext = BW'(hsz);

    assign full   = (pcnt_reg == CW'(DEPTH));
    assign ncount = pcnt_reg + CW'(1);
    assign nbytes = bcnt_reg + BW'(size_reg);

    always_comb
    begin
        if (cfg.size_mode)
        begin
            over = BCMP_W'(nbytes) >= BCMP_W'(cfg.max_bytes);
            mark = BCMP_W'(nbytes) >= BCMP_W'(cfg.mark_thresh_bytes);
        end
        else
        begin
            over = PCMP_W'(ncount) >= PCMP_W'(cfg.max_packets);
            mark = PCMP_W'(ncount) >= PCMP_W'(cfg.mark_thresh_packets);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        pcnt_next    = pcnt_reg;
        bcnt_next    = bcnt_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ostatus_next = ostatus_reg;
        oid_next     = oid_reg;
        osize_next   = osize_reg;
        ram_we       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next  = S_IDLE;
                    ovalid_next = 1'b1;
                    oid_next    = id_reg;
                    osize_next  = size_reg;
                    if (kind_reg == KIND_ENQ)
                    begin
                        if (full || over)
                        begin
                            ostatus_next = ST_DROP;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            tail_next    = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
                            pcnt_next    = ncount;
                            bcnt_next    = nbytes;
                            ostatus_next = mark ? ST_MARKED : ST_ACCEPT;
                        end
                    end
                    else if (pcnt_reg == '0)
                    begin
                        ostatus_next = ST_EMPTY;
                        oid_next     = '0;
                        osize_next   = '0;
                    end
                    else
                    begin
                        oid_next   = hid;
                        osize_next = hsz;
                        if (kind_reg == KIND_DEQ)
                        begin
                            ostatus_next = ST_DEQ;
                            head_next    = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                            pcnt_next    = pcnt_reg - CW'(1);
                            bcnt_next    = (bcnt_reg >= hsz_ext) ? bcnt_reg - hsz_ext : '0;
                        end
                        else
                        begin
                            // peek, and the unused kind behaves as peek
                            ostatus_next = ST_PEEK;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            pcnt_reg   <= '0;
            bcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            pcnt_reg   <= pcnt_next;
            bcnt_reg   <= bcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= in_kind;
            id_reg   <= in_id;
            size_reg <= in_size;
        end
        ostatus_reg <= ostatus_next;
        oid_reg     <= oid_next;
        osize_reg   <= osize_next;
    end

endmodule

// File: rtl/core/tail_drop_ecn_fifo_top.sv
// tail drop fifo with congestion marking: packet descriptor queue with its own occupancy counts
// a result beat is registered as the exec state ends, after its input beat is accepted;
// the input is ready only in the idle state, so a new item is taken only once the last
// has left exec, and exec holds while an earlier result beat still waits on the output
// reset: pointers and counts clear, config registers take their defaults; the ram is not cleared
// depends on tdef_pkg, tdef_cfg, tdef_core, tdef_ram
module tail_drop_ecn_fifo_top
    import tdef_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,   // packet_id[31:0], packet_size[47:32]
    input  logic [1:0]             s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [79:0]            m_tdata,   // head_id[31:0], head_size[47:32],
                                              // occupancy_packets[55:48],
                                              // occupancy_bytes[78:56], zero[79]
    output logic [2:0]             m_tuser    // status[2:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = ID_W + SIZE_W;

    cfg_t               cfg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;
    logic [ID_W-1:0]    head_id;
    logic [SIZE_W-1:0]  head_size;
    logic [OCC_P_W-1:0] occ_p;
    logic [OCC_B_W-1:0] occ_b;

    tdef_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tdef_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tdef_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_id      (s_tdata[31:0]),
        .in_size    (s_tdata[47:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_id     (head_id),
        .out_size   (head_size),
        .out_occ_p  (occ_p),
        .out_occ_b  (occ_b),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    assign m_tdata = {1'b0, occ_b, occ_p, head_size, head_id};

endmodule

// File: sim/tail_drop_ecn_fifo_top_tb.sv
// testbench for tail_drop_ecn_fifo_top: drives enqueue, dequeue and peek beats and
// checks every result beat against a mirror of the queue kept in the bench
// depends on tdef_pkg and the rtl under rtl/core
`timescale 1ns / 100ps

module tail_drop_ecn_fifo_top_tb;
    import tdef_pkg::*;

    localparam int FIFO_DEPTH = 128;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] size;
    } descr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] hid;
        logic [15:0] hsize;
        logic [7:0]  opk;
        logic [22:0] obytes;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [79:0]            m_tdata;
    logic [2:0]             m_tuser;

    // mirror of the queue and its registers
    cfg_t        cfg_shadow;
    logic [31:0] mir_id [FIFO_DEPTH];
    logic [15:0] mir_size [FIFO_DEPTH];
    int          mir_head;
    int          mir_tail;
    logic [8:0]  occ_pkts;
    logic [23:0] occ_bytes;

    descr_t   descr_q[$];
    outcome_t outcome_q[$];
    descr_t   on_wire;
    outcome_t want;
    int       fails = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       calm = 1'b0;
    logic [15:0] stall_pat = 16'hFFFF;
    int       stall_age = 0;
    int       sent;

    tail_drop_ecn_fifo_top #(.DEPTH(FIFO_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // advances the mirror by one item and returns the result beat it should cause
    function automatic outcome_t fifo_outcome(descr_t d);
        outcome_t   o;
        logic [8:0] ncount;
        logic [24:0] nbytes;
        logic       over;
        logic       mark;
        o = '0;
        if (d.kind == KIND_ENQ)
        begin
            o.hid = d.id;
            o.hsize = d.size;
            if (occ_pkts >= FIFO_DEPTH)
                o.status = ST_DROP;
            else
            begin
                ncount = occ_pkts + 9'd1;
                nbytes = {1'b0, occ_bytes} + 25'(d.size);
                if (cfg_shadow.size_mode)
                begin
                    over = nbytes >= 25'(cfg_shadow.max_bytes);
                    mark = nbytes >= 25'(cfg_shadow.mark_thresh_bytes);
                end
                else
                begin
                    over = ncount >= 9'(cfg_shadow.max_packets);
                    mark = ncount >= 9'(cfg_shadow.mark_thresh_packets);
                end
                if (over)
                    o.status = ST_DROP;
                else
                begin
                    mir_id[mir_tail] = d.id;
                    mir_size[mir_tail] = d.size;
                    mir_tail = (mir_tail + 1 >= FIFO_DEPTH) ? 0 : mir_tail + 1;
                    occ_pkts = ncount;
                    occ_bytes = nbytes[23:0];
                    o.status = mark ? ST_MARKED : ST_ACCEPT;
                end
            end
        end
        else if (occ_pkts == 0)
            o.status = ST_EMPTY;
        else
        begin
            o.hid = mir_id[mir_head];
            o.hsize = mir_size[mir_head];
            if (d.kind == KIND_DEQ)
            begin
                mir_head = (mir_head + 1 >= FIFO_DEPTH) ? 0 : mir_head + 1;
                occ_pkts = occ_pkts - 9'd1;
                occ_bytes = (occ_bytes >= 24'(o.hsize)) ? occ_bytes - 24'(o.hsize) : '0;
                o.status = ST_DEQ;
            end
            else
                o.status = ST_PEEK;
        end
        o.opk = occ_pkts[7:0];
        o.obytes = occ_bytes[22:0];
        return o;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                outcome_q = {outcome_q, fifo_outcome(on_wire)};
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (descr_q.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                on_wire = descr_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {on_wire.size, on_wire.id};
                s_tuser <= on_wire.kind;
                if (burst_left > 0)
                    burst_left--;
                else if (!calm)
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // receiver: rotating stall mask, reloaded now and then
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_age++;
            if (stall_age >= 64)
            begin
                stall_age = 0;
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom) & 16'($urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom) | 16'h0001;
                endcase
            end
            else
                stall_pat = {stall_pat[14:0], stall_pat[15]};
            m_tready <= calm | stall_pat[0];
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // monitor: every result beat is matched against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result beat with nothing due: expected none, %s %0d data %h",
                         $time, "actual status", m_tuser, m_tdata);
                fails++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("head_id", want.hid, m_tdata[31:0]);
                check_field("head_size", 32'(want.hsize), 32'(m_tdata[47:32]));
                check_field("occupancy_packets", 32'(want.opk), 32'(m_tdata[55:48]));
                check_field("occupancy_bytes", 32'(want.obytes), 32'(m_tdata[78:56]));
                check_field("pad", 32'd0, 32'(m_tdata[79]));
            end
        end
    end

    task automatic add_item(input logic [1:0] kind, input logic [31:0] id,
                            input logic [15:0] size);
        descr_t d;
        d.kind = kind;
        d.id = id;
        d.size = size;
        descr_q = {descr_q, d};
    endtask

    function automatic logic [15:0] pick_size(input bit heavy);
        logic [15:0] s;
        case (heavy ? 3 : $urandom_range(0, 6))
            0, 1, 2: s = 16'($urandom_range(0, 1500));
            3: s = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom);
            4: s = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'hFFFF;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    task automatic add_random_item(input int enq_pct, input bit heavy);
        logic [1:0] k;
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            k = KIND_ENQ;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: k = KIND_SPARE;
                3, 4, 5, 6, 7: k = KIND_PEEK;
                default: k = KIND_DEQ;
            endcase
        end
        add_item(k, $urandom, pick_size(heavy));
    endtask

    // waits until all beats are out and every result is back, then a little more
    task automatic wait_drained();
        while (descr_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SIZE_MODE:    cfg_shadow.size_mode = val[0];
            REG_MAX_PACKETS:  cfg_shadow.max_packets = val[7:0];
            REG_MAX_BYTES:    cfg_shadow.max_bytes = val;
            REG_MARK_BYTES:   cfg_shadow.mark_thresh_bytes = val;
            REG_MARK_PACKETS: cfg_shadow.mark_thresh_packets = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic [7:0] maxp,
                              input logic [23:0] maxb, input logic [23:0] markb,
                              input logic [7:0] markp);
        wait_drained();
        write_reg(REG_SIZE_MODE, 24'(mode));
        write_reg(REG_MAX_PACKETS, 24'(maxp));
        write_reg(REG_MAX_BYTES, maxb);
        write_reg(REG_MARK_BYTES, markb);
        write_reg(REG_MARK_PACKETS, 24'(markp));
    endtask

    task automatic random_config();
        logic [7:0]  mp;
        logic [7:0]  tp;
        logic [23:0] mb;
        logic [23:0] tb;
        case ($urandom_range(0, 5))
            0: mp = 8'd0;
            1: mp = 8'd128;
            2: mp = 8'd1;
            default: mp = 8'($urandom_range(2, 127));
        endcase
        case ($urandom_range(0, 4))
            0: tp = 8'd0;
            1: tp = 8'd128;
            default: tp = 8'($urandom_range(0, 128));
        endcase
        case ($urandom_range(0, 5))
            0: mb = 24'd0;
            1: mb = 24'hFFFFFF;
            2: mb = 24'($urandom_range(1, 3000));
            default: mb = 24'($urandom_range(3000, 300000));
        endcase
        case ($urandom_range(0, 4))
            0: tb = 24'd0;
            1: tb = 24'hFFFFFF;
            2: tb = 24'($urandom_range(0, mb));
            default: tb = 24'($urandom_range(0, 200000));
        endcase
        set_config(1'($urandom_range(0, 1)), mp, mb, tb, tp);
    endtask

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int pct;
        cfg_shadow = {SIZE_MODE_RST, MAX_PACKETS_RST, MAX_BYTES_RST, MARK_BYTES_RST,
                      MARK_PACKETS_RST};
        mir_head = 0;
        mir_tail = 0;
        occ_pkts = '0;
        occ_bytes = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: empty queue answers, extremes of id and size, spare kind acts as peek
        add_item(KIND_DEQ, 32'h1234_5678, 16'h00FF);
        add_item(KIND_PEEK, 32'h0, 16'h0);
        add_item(KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
        add_item(KIND_ENQ, 32'h0000_0000, 16'h0000);
        add_item(KIND_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
        add_item(KIND_PEEK, 32'h0, 16'h0);
        add_item(KIND_SPARE, 32'h0, 16'h0);
        add_item(KIND_DEQ, 32'h0, 16'h0);
        add_item(KIND_DEQ, 32'h0, 16'h0);
        add_item(KIND_DEQ, 32'h0, 16'h0);

        // zero packet limit drops everything
        set_config(1'b0, 8'd0, 24'hFFFFFF, 24'd0, 8'd0);
        add_item(KIND_ENQ, 32'hA5A5_5A5A, 16'd64);
        add_item(KIND_ENQ, 32'h5A5A_A5A5, 16'd0);
        // zero packet mark threshold marks everything
        set_config(1'b0, 8'd128, 24'd0, 24'hFFFFFF, 8'd0);
        add_item(KIND_ENQ, 32'h0000_0001, 16'd1500);
        add_item(KIND_ENQ, 32'h8000_0000, 16'd40);
        add_item(KIND_DEQ, 32'h0, 16'h0);
        add_item(KIND_DEQ, 32'h0, 16'h0);
        // zero byte limit drops even an empty packet
        set_config(1'b1, 8'd128, 24'd0, 24'd0, 8'd128);
        add_item(KIND_ENQ, 32'hDEAD_0000, 16'd0);
        // zero byte mark threshold
        set_config(1'b1, 8'd0, 24'hFFFFFF, 24'd0, 8'd128);
        add_item(KIND_ENQ, 32'h0BAD_F00D, 16'd9000);
        add_item(KIND_PEEK, 32'h0, 16'h0);
        add_item(KIND_DEQ, 32'h0, 16'h0);

        // fill the whole store with large packets, then past it to drop on full storage
        set_config(1'b1, 8'd128, 24'hFFFFFF, 24'($urandom_range(0, 8388480)), 8'd128);
        for (n = 0; n < 132; n++)
            add_item(KIND_ENQ, $urandom, pick_size(1'b1));
        wait_drained();
        for (n = 0; n < 132; n++)
            add_random_item(0, 1'b0);
        sent = 264;

        while (sent < 950)
        begin
            random_config();
            calm = ($urandom_range(0, 4) == 0);
            pct = $urandom_range(25, 85);
            n = $urandom_range(40, 120);
            repeat (n)
                add_random_item(pct, 1'b0);
            sent += n;
            // now and then hold the sender off until every result is back
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                repeat (n / 2)
                    add_random_item(100 - pct, 1'b0);
                sent += n / 2;
            end
        end

        wait_drained();
        calm = 1'b1;
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
